### sv/bva_pkg.sv
package bva_pkg;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 8;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int OP_W        = 4;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    typedef logic [DATA_W-1:0]    byte_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [OP_W-1:0]      op_t;
    typedef logic [DIV_CNT_W-1:0] div_cnt_t;

    localparam div_cnt_t DIV_LAST = div_cnt_t'(DATA_W - 1);
    localparam byte_t    BYTE_MAX = '1;
    localparam byte_t    BYTE_MIN = '0;

    localparam op_t OP_ADDN    = 4'd0;
    localparam op_t OP_ADDV    = 4'd1;
    localparam op_t OP_ASSIGNN = 4'd2;
    localparam op_t OP_ASSIGNV = 4'd3;
    localparam op_t OP_DEC     = 4'd4;
    localparam op_t OP_DIVN    = 4'd5;
    localparam op_t OP_DIVV    = 4'd6;
    localparam op_t OP_INC     = 4'd7;
    localparam op_t OP_LINDN   = 4'd8;
    localparam op_t OP_LINDV   = 4'd9;
    localparam op_t OP_MULN    = 4'd10;
    localparam op_t OP_MULV    = 4'd11;
    localparam op_t OP_RIND    = 4'd12;
    localparam op_t OP_SUBN    = 4'd13;
    localparam op_t OP_SUBV    = 4'd14;

endpackage

### sv/bva_req_if.sv
interface bva_req_if import bva_pkg::*; ();

    logic  valid;
    logic  ready;
    op_t   req_type;
    addr_t first_index;
    byte_t second_operand;

    modport source (output valid, output req_type, output first_index,
                    output second_operand, input ready);
    modport sink (input valid, input req_type, input first_index,
                  input second_operand, output ready);

endinterface

### sv/bva_res_if.sv
interface bva_res_if import bva_pkg::*; ();

    logic  valid;
    logic  ready;
    addr_t written_index;
    byte_t written_value;
    logic  divide_by_zero;

    modport source (output valid, output written_index, output written_value,
                    output divide_by_zero, input ready);
    modport sink (input valid, input written_index, input written_value,
                  input divide_by_zero, output ready);

endinterface

### sv/bva_ram.sv
module bva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/byte_variable_alu.sv
// byte_variable_alu: byte-variable command unit over a 256 x 8 store.
// req channel (sink): req_type, first_index, second_operand, one command per
// transfer; ready is high only while the unit is idle.
// res channel (source): written_index, written_value, divide_by_zero, one
// transfer per command, held in an output register.
// A command runs through the states S_RD_A, S_RD_B, S_CALC and S_OUT; rind
// adds S_RD_C (a third dependent store read), and a division with a non-zero
// divisor adds S_DIV (8 restoring-division steps). The store has a single read
// port with a registered output, and each operand read waits for the previous one.
// A new command is taken in the cycle after the previous result is loaded, so
// the unit never takes a command before the previous one is through.
// Reset clears a per-entry valid vector, so every variable reads as zero
// straight after reset; no clearing pass is needed.
// When res is stalled, the result stays in the output register; the next
// command is still taken and runs until its result is ready, then waits with
// its store write held back until the output register frees.
module byte_variable_alu import bva_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    bva_req_if.sink   req,
    bva_res_if.source res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD_A = 3'd1;
    localparam logic [2:0] S_RD_B = 3'd2;
    localparam logic [2:0] S_RD_C = 3'd3;
    localparam logic [2:0] S_CALC = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;
    logic                   vq_reg, vq_next;
    logic                   res_valid_reg, res_valid_next;
    div_cnt_t               cnt_reg, cnt_next;

    op_t   op_reg, op_next;
    addr_t a_reg, a_next;
    byte_t b_reg, b_next;
    byte_t cur_reg, cur_next;
    byte_t opv_reg, opv_next;
    addr_t tgt_reg, tgt_next;
    byte_t val_reg, val_next;
    logic  dz_reg, dz_next;
    logic  wr_reg, wr_next;
    byte_t rem_reg, rem_next;
    byte_t quo_reg, quo_next;
    byte_t dvs_reg, dvs_next;
    addr_t out_idx_reg, out_idx_next;
    byte_t out_val_reg, out_val_next;
    logic  out_dz_reg, out_dz_next;

    addr_t  rd_addr;
    byte_t  ram_rdata;
    byte_t  eff_rdata;
    logic   mem_we;
    byte_t  opnd;
    logic   opnd_imm;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     trial;
    logic   out_free;

    bva_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (tgt_reg),
        .wdata (val_reg),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign eff_rdata = vq_reg ? ram_rdata : BYTE_MIN;
    assign out_free  = !res_valid_reg || res.ready;
    assign mem_we    = (state_reg == S_OUT) && out_free && wr_reg;

    assign req.ready          = (state_reg == S_IDLE);
    assign res.valid          = res_valid_reg;
    assign res.written_index  = out_idx_reg;
    assign res.written_value  = out_val_reg;
    assign res.divide_by_zero = out_dz_reg;

    assign opnd_imm = (op_reg == OP_ADDN) || (op_reg == OP_ASSIGNN) || (op_reg == OP_DIVN)
                   || (op_reg == OP_LINDN) || (op_reg == OP_MULN) || (op_reg == OP_SUBN);
    assign opnd     = opnd_imm ? b_reg : opv_reg;
    assign prod     = {{DATA_W{1'b0}}, cur_reg} * {{DATA_W{1'b0}}, opnd};
    assign shifted  = {rem_reg, quo_reg[DATA_W-1]};
    assign trial    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = req.first_index;
            S_RD_A:  rd_addr = b_reg;
            S_RD_B:  rd_addr = eff_rdata;
            default: rd_addr = a_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        vq_next        = valid_reg[rd_addr];
        res_valid_next = res_valid_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cur_next       = cur_reg;
        opv_next       = opv_reg;
        tgt_next       = tgt_reg;
        val_next       = val_reg;
        dz_next        = dz_reg;
        wr_next        = wr_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_dz_next    = out_dz_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.req_type;
                    a_next     = req.first_index;
                    b_next     = req.second_operand;
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                cur_next   = eff_rdata;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                opv_next   = eff_rdata;
                state_next = (op_reg == OP_RIND) ? S_RD_C : S_CALC;
            end
            S_RD_C:
            begin
                opv_next   = eff_rdata;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                tgt_next   = a_reg;
                val_next   = cur_reg;
                dz_next    = 1'b0;
                wr_next    = 1'b1;
                state_next = S_OUT;
                case (op_reg)
                    OP_ADDN, OP_ADDV:       val_next = cur_reg + opnd;
                    OP_ASSIGNN, OP_ASSIGNV: val_next = opnd;
                    OP_RIND:                val_next = opv_reg;
                    OP_DEC:
                        val_next = (cur_reg != BYTE_MIN) ? cur_reg - 1'b1 : cur_reg;
                    OP_INC:
                        val_next = (cur_reg != BYTE_MAX) ? cur_reg + 1'b1 : cur_reg;
                    OP_MULN, OP_MULV:       val_next = prod[DATA_W-1:0];
                    OP_SUBN, OP_SUBV:       val_next = cur_reg - opnd;
                    OP_LINDN, OP_LINDV:
                    begin
                        tgt_next = cur_reg;
                        val_next = opnd;
                    end
                    OP_DIVN, OP_DIVV:
                    begin
                        if (opnd == BYTE_MIN)
                        begin
                            dz_next = 1'b1;
                            wr_next = 1'b0;
                        end
                        else
                        begin
                            rem_next   = BYTE_MIN;
                            quo_next   = cur_reg;
                            dvs_next   = opnd;
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                    end
                    default: wr_next = 1'b0;
                endcase
            end
            S_DIV:
            begin
                if (!trial[DATA_W])
                begin
                    rem_next = trial[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    val_next   = quo_next;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (wr_reg)
                    begin
                        valid_next[tgt_reg] = 1'b1;
                    end
                    res_valid_next = 1'b1;
                    out_idx_next   = tgt_reg;
                    out_val_next   = val_reg;
                    out_dz_next    = dz_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            vq_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            vq_reg        <= vq_next;
            res_valid_reg <= res_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        cur_reg     <= cur_next;
        opv_reg     <= opv_next;
        tgt_reg     <= tgt_next;
        val_reg     <= val_next;
        dz_reg      <= dz_next;
        wr_reg      <= wr_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        out_idx_reg <= out_idx_next;
        out_val_reg <= out_val_next;
        out_dz_reg  <= out_dz_next;
    end

    // divider never runs with a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dvs_reg != BYTE_MIN)
        else $error("divider running with zero divisor");

    // a store write always comes with a new result
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> res.valid && res.written_index == $past(tgt_reg))
        else $error("store write without matching result");

    // a flagged division never writes the store
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && dz_reg |-> !mem_we)
        else $error("store written on division by zero");

    // a written entry reads as valid afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(tgt_reg)])
        else $error("valid bit not set on write");

    // the divider finishes after its last step
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == DIV_LAST |=> state_reg == S_OUT)
        else $error("divider overran");

endmodule
